// ===== design/i2csrw_pkg.sv =====
`default_nettype none

package i2csrw_pkg;

	// window depths
	localparam int RX_DEPTH = 16;
	localparam int TX_DEPTH = 16;
	localparam int MAX_DEPTH = (RX_DEPTH > TX_DEPTH) ? RX_DEPTH : TX_DEPTH;
	localparam int RX_IW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
	localparam int TX_IW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
	localparam int PTR_W = $clog2(MAX_DEPTH + 1);

	// field widths
	localparam int SIZE_W = 5;
	localparam int IN_DATA_W = 32;
	localparam int OUT_DATA_W = 24;

	// register indexes
	localparam logic REG_RX_SIZE = 1'b0;
	localparam logic REG_TX_SIZE = 1'b1;
	localparam logic [SIZE_W-1:0] SIZE_RESET = 5'd16;

	// item kinds
	typedef enum logic [1:0] {
		KIND_BUS   = 2'd0,
		KIND_LOAD  = 2'd1,
		KIND_READ  = 2'd2,
		KIND_CLEAR = 2'd3
	} kind_t;

	// slave status codes
	localparam logic [7:0] ST_WR_ADDR0 = 8'h60;
	localparam logic [7:0] ST_WR_ADDR1 = 8'h68;
	localparam logic [7:0] ST_WR_ADDR2 = 8'h70;
	localparam logic [7:0] ST_WR_ADDR3 = 8'h78;
	localparam logic [7:0] ST_RX_ACK0  = 8'h80;
	localparam logic [7:0] ST_RX_ACK1  = 8'h90;
	localparam logic [7:0] ST_RX_NACK0 = 8'h88;
	localparam logic [7:0] ST_RX_NACK1 = 8'h98;
	localparam logic [7:0] ST_STOP     = 8'hA0;
	localparam logic [7:0] ST_RD_ADDR0 = 8'hA8;
	localparam logic [7:0] ST_RD_ADDR1 = 8'hB0;
	localparam logic [7:0] ST_TX_ACK   = 8'hB8;
	localparam logic [7:0] ST_REARM    = 8'hC8;
	localparam logic [7:0] CHANGE_MARK = 8'h02;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] status_code;
		logic [7:0] bus_byte;
		logic [3:0] host_index;
		logic [7:0] host_value;
	} item_t;

	typedef struct packed {
		logic [7:0] host_data;
		logic       changed;
		logic       rearm_ack;
		logic       release_bus;
		logic       tx_loaded;
		logic [7:0] tx_byte;
	} result_t;

endpackage

`default_nettype wire

// ===== design/i2csrw_core.sv =====
`default_nettype none

module i2csrw_core (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          go,
	input  i2csrw_pkg::item_t            item,
	input  wire [i2csrw_pkg::SIZE_W-1:0] rx_size,
	input  wire [i2csrw_pkg::SIZE_W-1:0] tx_size,
	output i2csrw_pkg::result_t          result
);
	import i2csrw_pkg::*;

	logic [PTR_W-1:0] ptr_q, ptr_d;
	logic             pending_q, pending_d;
	logic             change_q, change_d;
	logic [7:0]       rxw_q [RX_DEPTH];
	logic [7:0]       txw_q [TX_DEPTH];

	logic [PTR_W-1:0] rs, ts, rs_m1, rx_at;
	logic             rx_wr, tx_wr;
	logic [7:0]       tx_sel;

	// sizes clipped to the window depths
	assign rs = (32'(rx_size) > RX_DEPTH) ? PTR_W'(RX_DEPTH) : PTR_W'(rx_size);
	assign ts = (32'(tx_size) > TX_DEPTH) ? PTR_W'(TX_DEPTH) : PTR_W'(tx_size);
	assign rs_m1 = rs - 1'b1;
	assign rx_at = (ptr_q < rs_m1) ? ptr_q : rs_m1;
	assign tx_sel = (ptr_q < ts) ? txw_q[TX_IW'(ptr_q)] : 8'h00;

	// next state and result word
	always_comb begin
		ptr_d = ptr_q;
		pending_d = pending_q;
		change_d = change_q;
		rx_wr = 1'b0;
		tx_wr = 1'b0;
		result = '0;
		unique case (item.kind)
			KIND_BUS: begin
				unique case (item.status_code)
					ST_WR_ADDR0, ST_WR_ADDR1, ST_WR_ADDR2, ST_WR_ADDR3: begin
						ptr_d = '0;
					end
					ST_RX_ACK0, ST_RX_ACK1: begin
						if (rs != '0) begin
							rx_wr = 1'b1;
							ptr_d = (rx_at < rs_m1) ? rx_at + 1'b1 : rx_at;
							pending_d = 1'b1;
						end
					end
					ST_RX_NACK0, ST_RX_NACK1: begin
						result.release_bus = 1'b1;
					end
					ST_STOP: begin
						if (pending_q && rxw_q[0] == CHANGE_MARK) begin
							pending_d = 1'b0;
							change_d = 1'b1;
						end
						ptr_d = '0;
					end
					ST_RD_ADDR0, ST_RD_ADDR1: begin
						ptr_d = '0;
						if (ts != '0) begin
							result.tx_byte = txw_q[0];
							ptr_d = PTR_W'(1);
						end
						result.tx_loaded = 1'b1;
					end
					ST_TX_ACK: begin
						if (ptr_q < ts) begin
							ptr_d = ptr_q + 1'b1;
						end
						result.tx_byte = tx_sel;
						result.tx_loaded = 1'b1;
					end
					ST_REARM: begin
						result.rearm_ack = 1'b1;
					end
					default: begin
					end
				endcase
			end
			KIND_LOAD: begin
				tx_wr = (32'(item.host_index) < TX_DEPTH);
			end
			KIND_READ: begin
				if (32'(item.host_index) < RX_DEPTH) begin
					result.host_data = rxw_q[RX_IW'(item.host_index)];
				end
			end
			KIND_CLEAR: begin
				change_d = 1'b0;
			end
			default: begin
			end
		endcase
		result.changed = change_d;
	end

	// pointer and flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
			pending_q <= 1'b0;
			change_q <= 1'b0;
		end else if (go) begin
			ptr_q <= ptr_d;
			pending_q <= pending_d;
			change_q <= change_d;
		end
	end

	// register windows
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < RX_DEPTH; i++) rxw_q[i] <= '0;
			for (int i = 0; i < TX_DEPTH; i++) txw_q[i] <= '0;
		end else if (go) begin
			if (rx_wr) begin
				rxw_q[RX_IW'(rx_at)] <= item.bus_byte;
			end
			if (tx_wr) begin
				txw_q[TX_IW'(item.host_index)] <= item.host_value;
			end
		end
	end

	// checks
	a_ptr_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(ptr_q) <= MAX_DEPTH)
		else $error("byte pointer beyond window");

	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		go && item.kind == KIND_CLEAR |=> !change_q)
		else $error("change flag not cleared");

	a_flag_fall: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(change_q) |-> $past(go && item.kind == KIND_CLEAR))
		else $error("change flag dropped without a clear");

	a_stop_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		go && item.kind == KIND_BUS && item.status_code == ST_STOP |=> ptr_q == '0)
		else $error("pointer not cleared on stop");

endmodule

`default_nettype wire

// ===== design/i2c_slave_register_window.sv =====
// channel  | dir | handshake                     | payload
// s_axis   | in  | s_axis_tvalid / s_axis_tready | tuser: kind; tdata: event and host fields
// m_axis   | out | m_axis_tvalid / m_axis_tready | tdata: result flags and bytes
// cfg      | in  | cfg_valid / cfg_ready         | cfg_index, cfg_data (rx_size, tx_size)
//
// an item is held in the input register and is worked out into the result register
// when go is high; one item per cycle is sustained while results are taken
// the window update in the core is the single pass between the two registers
// reset clears the pointer, flags, both windows and sets both sizes to 16
// a stalled result holds the input register, which then holds s_axis_tready low
`default_nettype none

module i2c_slave_register_window (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire [31:0] s_axis_tdata,  // status_code, bus_byte, host_index, host_value, zero pad
	input  wire [1:0]  s_axis_tuser,  // kind
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [23:0] m_axis_tdata, // tx_byte, tx_loaded, release_bus, rearm_ack, changed,
	                                  // host_data, zero pad
	input  wire        cfg_valid,
	output logic       cfg_ready,
	input  wire        cfg_index,
	input  wire [4:0]  cfg_data
);
	import i2csrw_pkg::*;

	logic                valid_s1;
	item_t               item_s1;
	logic                out_valid_q;
	result_t             out_q;
	result_t             result;
	logic                go;
	logic [SIZE_W-1:0]   rx_size_q, tx_size_q;

	// advance when the result register is free or being taken
	assign go = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || go;
	assign cfg_ready = 1'b1;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata = {{(OUT_DATA_W - $bits(result_t)){1'b0}}, out_q};

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rx_size_q <= SIZE_RESET;
			tx_size_q <= SIZE_RESET;
		end else if (cfg_valid) begin
			if (cfg_index == REG_RX_SIZE) begin
				rx_size_q <= cfg_data;
			end else begin
				tx_size_q <= cfg_data;
			end
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.kind <= kind_t'(s_axis_tuser);
			item_s1.status_code <= s_axis_tdata[7:0];
			item_s1.bus_byte <= s_axis_tdata[15:8];
			item_s1.host_index <= s_axis_tdata[19:16];
			item_s1.host_value <= s_axis_tdata[27:20];
		end
	end

	i2csrw_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.go      (go),
		.item    (item_s1),
		.rx_size (rx_size_q),
		.tx_size (tx_size_q),
		.result  (result)
	);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (go) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			out_q <= result;
		end
	end

endmodule

`default_nettype wire
